>>> rtl/kvbf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers of the value/bias Kalman filter.
// No dependencies.
package kvbf_pkg;

  localparam int DW = 32;   // data width, signed Q16.16
  localparam int FB = 16;   // fraction bits
  localparam int CW = 3;    // config index width

  typedef logic signed [DW-1:0] data_t;
  typedef logic [DW-2:0]        udata_t;

  // config register indexes
  localparam logic [CW-1:0] REG_INIT_VALUE   = 3'd0;
  localparam logic [CW-1:0] REG_LIFESPAN     = 3'd1;
  localparam logic [CW-1:0] REG_VALUE_NOISE  = 3'd2;
  localparam logic [CW-1:0] REG_BIAS_NOISE   = 3'd3;
  localparam logic [CW-1:0] REG_SENSOR_NOISE = 3'd4;

  localparam data_t MAXV = {1'b0, {(DW-1){1'b1}}};
  localparam data_t MINV = {1'b1, {(DW-1){1'b0}}};

  // saturating add / subtract
  function automatic data_t sat_add(input data_t a, input data_t b, input logic sub);
    logic signed [DW:0] s;
    begin
      if (sub) s = {a[DW-1], a} - {b[DW-1], b};
      else     s = {a[DW-1], a} + {b[DW-1], b};
      if (s[DW] != s[DW-1]) sat_add = s[DW] ? MINV : MAXV;
      else                  sat_add = s[DW-1:0];
    end
  endfunction

  // magnitude of a signed word, as unsigned
  function automatic logic [DW-1:0] mag(input data_t x);
    begin
      mag = x[DW-1] ? (~x + 1'b1) : x;
    end
  endfunction

  // apply sign to a magnitude and saturate
  function automatic data_t sign_sat(input logic [DW+FB-1:0] m, input logic neg);
    logic [DW-1:0] lo;
    begin
      lo = m[DW-1:0];
      if (neg) sign_sat = (m > {{(FB+1){1'b0}}, {(DW-1){1'b1}}}) ? MINV : data_t'(~lo + 1'b1);
      else     sign_sat = (m > {{(FB+1){1'b0}}, {(DW-1){1'b1}}}) ? MAXV : data_t'(lo);
    end
  endfunction

endpackage

>>> rtl/kvbf_in_if.sv
`timescale 1ns / 1ps
// Input channel of the value/bias Kalman filter: measurement item with valid/ready.
// Depends on kvbf_pkg.
interface kvbf_in_if;
  import kvbf_pkg::*;
  logic   valid;
  logic   ready;
  data_t  measured_value;
  data_t  measured_rate;
  udata_t elapsed_time;
  modport source(output valid, measured_value, measured_rate, elapsed_time, input ready);
  modport sink(input valid, measured_value, measured_rate, elapsed_time, output ready);
endinterface

>>> rtl/kvbf_out_if.sv
`timescale 1ns / 1ps
// Result channel of the value/bias Kalman filter: estimate item with valid/ready.
// Depends on kvbf_pkg.
interface kvbf_out_if;
  import kvbf_pkg::*;
  logic  valid;
  logic  ready;
  data_t filtered_value;
  data_t estimated_bias;
  data_t corrected_rate;
  logic  expired;
  modport source(output valid, filtered_value, estimated_bias, corrected_rate, expired,
                 input ready);
  modport sink(input valid, filtered_value, estimated_bias, corrected_rate, expired,
               output ready);
endinterface

>>> rtl/kalman_value_bias_filter_top.sv
`timescale 1ns / 1ps
// Two-state (value, rate bias) Kalman filter, Q16.16, one shared multiplier and adder.
// Depends on kvbf_pkg, kvbf_in_if, kvbf_out_if.

// An item is taken only while the sequencer is idle. An expired item (elapsed time
// above lifespan) leaves the state unchanged: the sequencer goes from idle straight
// to the done step, which loads its result. A normal item runs through the
// prediction and covariance update steps, two restoring divisions for the gains,
// the innovation step and six multiply/add pairs for the correction; the done step
// then loads the result register and the sequencer returns to idle. When P00 plus
// sensor noise is zero the divisions are skipped and both gains are set to zero. All
// arithmetic goes through a single 32x32 multiplier, one saturating adder and a
// one-bit-per-cycle divider. The result register holds the item until taken while
// the next item is accepted; a result still waiting there when the next item
// finishes stalls the sequencer.
module kalman_value_bias_filter_top
  import kvbf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CW-1:0]     cfg_index,
  input  logic [DW-1:0]     cfg_data,
  kvbf_in_if.sink           in_ch,
  kvbf_out_if.source        out_ch
);

  // sequencer steps
  localparam logic [4:0] ST_IDLE = 5'd0,  ST_LR   = 5'd1,  ST_MVAL = 5'd2,  ST_AVAL = 5'd3,
                         ST_MDTP = 5'd4,  ST_ADTP = 5'd5,  ST_AT1  = 5'd6,  ST_AT2  = 5'd7,
                         ST_AT3  = 5'd8,  ST_MP00 = 5'd9,  ST_AP00 = 5'd10, ST_AP01 = 5'd11,
                         ST_AP10 = 5'd12, ST_MP11 = 5'd13, ST_AP11 = 5'd14, ST_AS   = 5'd15,
                         ST_DSTA = 5'd16, ST_DRUN = 5'd17, ST_AY   = 5'd18, ST_MKV  = 5'd19,
                         ST_AKV  = 5'd20, ST_MKB  = 5'd21, ST_AKB  = 5'd22, ST_MC2  = 5'd23,
                         ST_AC2  = 5'd24, ST_MC3  = 5'd25, ST_AC3  = 5'd26, ST_MC0  = 5'd27,
                         ST_AC0  = 5'd28, ST_MC1  = 5'd29, ST_AC1  = 5'd30, ST_DONE = 5'd31;
  localparam int QW = DW + FB;
  localparam logic [5:0] DIV_LAST = 6'(QW - 1);

  logic [4:0] st_r;

  // config registers
  udata_t lifespan_r, vnoise_r, bnoise_r, snoise_r;

  // filter state and scratch
  data_t val_r, bias_r, lr_r, p00_r, p01_r, p10_r, p11_r;
  data_t mv_r, mr_r, t_r, dtp_r, y_r, k0_r, k1_r;
  udata_t dt_r;
  logic  exp_r;

  // multiplier
  logic [2*DW-1:0] prod_r;
  logic            mneg_r;
  data_t           mul_a, mul_b, q_res;

  // divider
  logic [QW-1:0]   dd_r;
  logic [DW-1:0]   rem_r, dsor_r, rem_n;
  logic [5:0]      dcnt_r;
  logic            dneg_r, dsel_r, dge;
  logic [DW:0]     rem_sh;
  data_t           d_res;

  // adder
  data_t add_a, add_b, add_res;
  logic  add_sub;

  // output register
  logic  ovalid_r;
  data_t ofv_r, ofb_r, ocr_r;
  logic  oexp_r;

  data_t dt_s, vn_s, bn_s, sn_s;
  assign dt_s = {1'b0, dt_r};
  assign vn_s = {1'b0, vnoise_r};
  assign bn_s = {1'b0, bnoise_r};
  assign sn_s = {1'b0, snoise_r};

  logic in_acc, out_free;
  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !ovalid_r || out_ch.ready;

  assign out_ch.valid          = ovalid_r;
  assign out_ch.filtered_value = ofv_r;
  assign out_ch.estimated_bias = ofb_r;
  assign out_ch.corrected_rate = ocr_r;
  assign out_ch.expired        = oexp_r;

  // product scaling and saturation
  assign q_res = sign_sat(prod_r[2*DW-1:FB], mneg_r);

  // divider step: one quotient bit per cycle
  assign rem_sh = {rem_r, dd_r[QW-1]};
  assign dge    = rem_sh >= {1'b0, dsor_r};
  assign rem_n  = dge ? DW'(rem_sh - {1'b0, dsor_r}) : rem_sh[DW-1:0];
  assign d_res  = sign_sat({dd_r[QW-2:0], dge}, dneg_r);

  // operand selection for the shared multiplier and adder
  always_comb begin
    mul_a   = dt_s;
    mul_b   = lr_r;
    add_a   = q_res;
    add_b   = '0;
    add_sub = 1'b0;
    case (st_r)
      ST_LR:   begin add_a = mr_r;  add_b = bias_r; add_sub = 1'b1; end
      ST_MDTP: mul_b = p11_r;
      ST_AVAL: begin add_a = val_r; add_b = q_res; end
      ST_AT1:  begin add_a = dtp_r; add_b = p01_r; add_sub = 1'b1; end
      ST_AT2:  begin add_a = t_r;   add_b = p10_r; add_sub = 1'b1; end
      ST_AT3:  begin add_a = t_r;   add_b = vn_s; end
      ST_MP00: mul_b = t_r;
      ST_AP00: begin add_a = p00_r; add_b = q_res; end
      ST_AP01: begin add_a = p01_r; add_b = dtp_r; add_sub = 1'b1; end
      ST_AP10: begin add_a = p10_r; add_b = dtp_r; add_sub = 1'b1; end
      ST_MP11: begin mul_a = bn_s; mul_b = dt_s; end
      ST_AP11: begin add_a = p11_r; add_b = q_res; end
      ST_AS:   begin add_a = p00_r; add_b = sn_s; end
      ST_AY:   begin add_a = mv_r;  add_b = val_r; add_sub = 1'b1; end
      ST_MKV:  begin mul_a = k0_r;  mul_b = y_r; end
      ST_AKV:  begin add_a = val_r; add_b = q_res; end
      ST_MKB:  begin mul_a = k1_r;  mul_b = y_r; end
      ST_AKB:  begin add_a = bias_r; add_b = q_res; end
      ST_MC2:  begin mul_a = k1_r;  mul_b = p00_r; end
      ST_AC2:  begin add_a = p10_r; add_b = q_res; add_sub = 1'b1; end
      ST_MC3:  begin mul_a = k1_r;  mul_b = p01_r; end
      ST_AC3:  begin add_a = p11_r; add_b = q_res; add_sub = 1'b1; end
      ST_MC0:  begin mul_a = k0_r;  mul_b = p00_r; end
      ST_AC0:  begin add_a = p00_r; add_b = q_res; add_sub = 1'b1; end
      ST_MC1:  begin mul_a = k0_r;  mul_b = p01_r; end
      ST_AC1:  begin add_a = p01_r; add_b = q_res; add_sub = 1'b1; end
      default: ;
    endcase
  end

  assign add_res = sat_add(add_a, add_b, add_sub);

  // payload and scratch registers, shared multiplier product
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mv_r <= in_ch.measured_value;
      mr_r <= in_ch.measured_rate;
      dt_r <= in_ch.elapsed_time;
    end
    prod_r <= mag(mul_a) * mag(mul_b);
    mneg_r <= mul_a[DW-1] ^ mul_b[DW-1];
    case (st_r)
      ST_ADTP: dtp_r <= add_res;
      ST_AT1, ST_AT2, ST_AT3, ST_AS: t_r <= add_res;
      ST_AY:   y_r <= add_res;
      default: ;
    endcase
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (st_r == ST_DSTA || (st_r == ST_DRUN && dcnt_r == DIV_LAST && !dsel_r)) begin
      dd_r   <= (st_r == ST_DSTA) ? {mag(p00_r), {FB{1'b0}}} : {mag(p10_r), {FB{1'b0}}};
      rem_r  <= '0;
      dsor_r <= mag(t_r);
      dneg_r <= ((st_r == ST_DSTA) ? p00_r[DW-1] : p10_r[DW-1]) ^ t_r[DW-1];
    end else if (st_r == ST_DRUN) begin
      dd_r  <= {dd_r[QW-2:0], dge};
      rem_r <= rem_n;
    end
  end

  // sequencer, state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      lifespan_r <= udata_t'(65536);
      vnoise_r   <= udata_t'(655);
      bnoise_r   <= udata_t'(197);
      snoise_r   <= udata_t'(19661);
      val_r      <= '0;
      bias_r     <= '0;
      lr_r       <= '0;
      p00_r      <= '0;
      p01_r      <= '0;
      p10_r      <= '0;
      p11_r      <= '0;
      k0_r       <= '0;
      k1_r       <= '0;
      exp_r      <= 1'b0;
      dcnt_r     <= '0;
      dsel_r     <= 1'b0;
      ovalid_r   <= 1'b0;
    end else begin
      // result taken; a finishing item reloads the register below
      if (ovalid_r && out_ch.ready && st_r != ST_DONE) ovalid_r <= 1'b0;

      if (cfg_we) begin
        case (cfg_index)
          REG_INIT_VALUE:   val_r      <= cfg_data;
          REG_LIFESPAN:     lifespan_r <= cfg_data[DW-2:0];
          REG_VALUE_NOISE:  vnoise_r   <= cfg_data[DW-2:0];
          REG_BIAS_NOISE:   bnoise_r   <= cfg_data[DW-2:0];
          REG_SENSOR_NOISE: snoise_r   <= cfg_data[DW-2:0];
          default: ;
        endcase
      end

      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            exp_r <= in_ch.elapsed_time > lifespan_r;
            st_r  <= (in_ch.elapsed_time > lifespan_r) ? ST_DONE : ST_LR;
          end
        end
        ST_LR:   begin lr_r  <= add_res; st_r <= ST_MVAL; end
        ST_AVAL: begin val_r <= add_res; st_r <= ST_MDTP; end
        ST_AP00: begin p00_r <= add_res; st_r <= ST_AP01; end
        ST_AP01: begin p01_r <= add_res; st_r <= ST_AP10; end
        ST_AP10: begin p10_r <= add_res; st_r <= ST_MP11; end
        ST_AP11: begin p11_r <= add_res; st_r <= ST_AS; end
        ST_DSTA: begin
          dcnt_r <= '0;
          dsel_r <= 1'b0;
          if (t_r == '0) begin
            k0_r <= '0;
            k1_r <= '0;
            st_r <= ST_AY;
          end else begin
            st_r <= ST_DRUN;
          end
        end
        ST_DRUN: begin
          if (dcnt_r == DIV_LAST) begin
            dcnt_r <= '0;
            if (!dsel_r) begin
              k0_r   <= d_res;
              dsel_r <= 1'b1;
            end else begin
              k1_r <= d_res;
              st_r <= ST_AY;
            end
          end else begin
            dcnt_r <= dcnt_r + 1'b1;
          end
        end
        ST_AKV:  begin val_r  <= add_res; st_r <= ST_MKB; end
        ST_AKB:  begin bias_r <= add_res; st_r <= ST_MC2; end
        ST_AC2:  begin p10_r  <= add_res; st_r <= ST_MC3; end
        ST_AC3:  begin p11_r  <= add_res; st_r <= ST_MC0; end
        ST_AC0:  begin p00_r  <= add_res; st_r <= ST_MC1; end
        ST_AC1:  begin p01_r  <= add_res; st_r <= ST_DONE; end
        ST_DONE: begin
          if (out_free) begin
            ovalid_r <= 1'b1;
            ofv_r    <= val_r;
            ofb_r    <= bias_r;
            ocr_r    <= lr_r;
            oexp_r   <= exp_r;
            st_r     <= ST_IDLE;
          end
        end
        default: st_r <= st_r + 1'b1;
      endcase
    end
  end

endmodule
